[sv/srrw_pkg.sv]
// srrw_pkg: shared widths, codes and stream packing for the selective-repeat
// receive window. No dependencies; imported by the receive window top level.
`default_nettype none

package srrw_pkg;

  // field widths of the input and result items
  localparam int SEQ_W   = 16;
  localparam int DATA_W  = 64;
  localparam int LEN_W   = 4;
  localparam int KIND_W  = 2;
  localparam int ACK_W   = 6;
  localparam int TOTAL_W = 32;

  // configuration registers
  localparam int WSIZE_W    = 6;
  localparam int EXP_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // defaults for the top level parameters
  localparam int DEF_MAX_WINDOW = 32;
  localparam int DEF_DATA_BYTES = 8;

  // stream packing, rounded up to whole bytes
  localparam int IN_FIELDS_W  = SEQ_W + DATA_W + LEN_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ACK_W + DATA_W + LEN_W + TOTAL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // end of transfer marker, -2 in two's complement
  localparam logic [SEQ_W-1:0] SEQ_END_MARK = 16'hFFFE;

  // reset value of the window size register
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 6'd8;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ACK      = 2'd0,
    KIND_DELIVER  = 2'd1,
    KIND_FINISHED = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE    = 1'b0,
    REG_EXPECTED_BYTES = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

[sv/srrw_slot_store.sv]
// srrw_slot_store: slot buffer of the receive window, one entry per sequence
// number, one write port and one read port with registered read data.
// No package dependencies.
`default_nettype none

module srrw_slot_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 68
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/selective_repeat_receive_window.sv]
// selective_repeat_receive_window: top level of the selective-repeat receiver.
// Depends on srrw_pkg and srrw_slot_store.
//
// Usage:
//   Packets arrive on the s_axis channel, one item per packet. Results leave
//   on the m_axis channel: an acknowledgment per packet in range, then, when
//   the packet fills the window base, one delivery item per buffered payload
//   in order; tlast marks the final result of a packet. Out of range
//   sequence numbers give no result. Once the byte total reaches the
//   expected total, sequence -2 gives a finished item.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i while the
//   block is idle; a window size write clears all received marks and the base.
// Timing:
//   A packet occupies the block, taking no new packet, through capture, then
//   window check and slot write; a packet that fills the base slot adds the
//   slot buffer read, then one delivered payload per cycle while the output
//   is free. The single read port of the slot buffer sets this rate.
//   Acks and finished items appear the cycle after the window check.
// Reset: marks, base, byte count and closing phase clear at once, no sweep.
// Stalls: a held result does not block input capture; the next result waits
//   in place until m_axis_tready_i frees the output register.
`default_nettype none

module selective_repeat_receive_window
  import srrw_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int DATA_BYTES = DEF_DATA_BYTES
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // packet input
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // seq_num [15:0], payload_data [79:16], payload_len [83:80], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // result output
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  // ack_seq [5:0], out_data [69:6], out_len [73:70], total_bytes [105:74], pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // kind [1:0]
  output logic [KIND_W-1:0]           m_axis_tuser_o,
  output logic                        m_axis_tlast_o
);

  localparam int SLOTS   = 2 * MAX_WINDOW;
  localparam int IW      = $clog2(SLOTS);
  localparam int WW      = $clog2(MAX_WINDOW + 1);
  localparam int SPW     = WW + 1;
  localparam int STORE_W = 8 * DATA_BYTES;
  localparam int ENTRY_W = STORE_W + LEN_W;
  localparam int OUT_PAD = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_READ,
    ST_DELIVER
  } state_e;

  state_e               state_q;

  // configuration
  logic [WSIZE_W-1:0]   window_size_q;
  logic [EXP_W-1:0]     expected_q;

  // window state
  logic [SLOTS-1:0]     rx_q;
  logic [IW-1:0]        base_q;
  logic [TOTAL_W-1:0]   delivered_q;
  logic                 closing_q;
  logic [WW-1:0]        cnt_q;

  // captured packet
  logic [SEQ_W-1:0]     seq_q;
  logic [STORE_W-1:0]   data_q;
  logic [LEN_W-1:0]     len_q;

  // output register
  logic                 out_valid_q;
  kind_e                out_kind_q;
  logic [ACK_W-1:0]     out_seq_q;
  logic [DATA_W-1:0]    out_data_q;
  logic [LEN_W-1:0]     out_len_q;
  logic [TOTAL_W-1:0]   out_total_q;
  logic                 out_last_q;

  // input capture: saturate the length and clear bytes beyond it
  logic [LEN_W-1:0]     len_raw;
  logic [LEN_W-1:0]     len_sat;
  logic [STORE_W-1:0]   data_mask;
  logic                 in_fire;

  assign len_raw = s_axis_tdata_i[SEQ_W+DATA_W +: LEN_W];
  assign len_sat = (len_raw > LEN_W'(DATA_BYTES)) ? LEN_W'(DATA_BYTES) : len_raw;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    for (int b = 0; b < DATA_BYTES; b++) begin
      data_mask[8*b +: 8] = (LEN_W'(b) < len_sat) ? s_axis_tdata_i[SEQ_W+8*b +: 8] : 8'h00;
    end
  end

  // effective window and sequence space
  logic [WW-1:0]        w_eff;
  logic [SPW-1:0]       space;

  always_comb begin
    if (window_size_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(window_size_q) > 32'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = WW'(window_size_q);
    end
    space = {w_eff, 1'b0};
  end

  // window check of the captured packet
  logic                 is_end;
  logic                 seq_ok;
  logic [IW-1:0]        s_idx;
  logic [SPW:0]         diff;
  logic [SPW:0]         off;
  logic                 in_win;
  logic                 out_free;
  logic                 slide_start;

  assign is_end = (seq_q == SEQ_END_MARK) && closing_q;
  assign seq_ok = !seq_q[SEQ_W-1] && (seq_q < SEQ_W'(space));
  assign s_idx  = seq_q[IW-1:0];
  assign diff   = (SPW+1)'(s_idx) + (SPW+1)'(space) - (SPW+1)'(base_q);
  assign off    = (diff >= (SPW+1)'(space)) ? diff - (SPW+1)'(space) : diff;
  assign in_win = (off < (SPW+1)'(w_eff)) && !closing_q;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign slide_start = !is_end && seq_ok && in_win && (s_idx == base_q);

  // slot buffer
  logic                 mem_we;
  logic                 mem_re;
  logic [IW-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]   mem_rdata;
  logic [STORE_W-1:0]   rd_payload;
  logic [LEN_W-1:0]     rd_len;

  assign rd_payload = mem_rdata[STORE_W-1:0];
  assign rd_len     = mem_rdata[ENTRY_W-1 -: LEN_W];

  // delivery step: saturating byte count, next base, continue or stop
  logic [TOTAL_W:0]     sum;
  logic [TOTAL_W-1:0]   delivered_nx;
  logic [IW-1:0]        base_nx;
  logic [WW:0]          cnt_nx;
  logic                 more;
  logic                 deliver_fire;
  logic                 out_load;

  assign sum          = {1'b0, delivered_q} + (TOTAL_W+1)'(rd_len);
  assign delivered_nx = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign base_nx      = (SPW'(base_q) + SPW'(1) == space) ? '0 : base_q + IW'(1);
  assign cnt_nx       = (WW+1)'(cnt_q) + (WW+1)'(1);
  assign more         = rx_q[base_nx] && (cnt_nx < (WW+1)'(w_eff));
  assign deliver_fire = (state_q == ST_DELIVER) && out_free;

  // a new result enters the output register
  assign out_load = ((state_q == ST_EVAL) && out_free && (is_end || seq_ok)) || deliver_fire;

  assign mem_we    = (state_q == ST_EVAL) && out_free && !is_end && seq_ok && in_win;
  assign mem_re    = (state_q == ST_READ) || (deliver_fire && more);
  assign mem_raddr = (state_q == ST_READ) ? base_q : base_nx;

  srrw_slot_store #(
    .DEPTH (SLOTS),
    .WIDTH (ENTRY_W)
  ) u_slot_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (s_idx),
    .wdata_i ({len_q, data_q}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer, window state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      window_size_q <= WINDOW_SIZE_RESET;
      expected_q    <= '0;
      rx_q          <= '0;
      base_q        <= '0;
      delivered_q   <= '0;
      closing_q     <= 1'b0;
      cnt_q         <= '0;
      seq_q         <= '0;
      data_q        <= '0;
      len_q         <= '0;
      out_valid_q   <= 1'b0;
      out_kind_q    <= KIND_ACK;
      out_seq_q     <= '0;
      out_data_q    <= '0;
      out_len_q     <= '0;
      out_total_q   <= '0;
      out_last_q    <= 1'b0;
    end else begin
      // output register loads a result or drains when taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            seq_q   <= s_axis_tdata_i[SEQ_W-1:0];
            data_q  <= data_mask;
            len_q   <= len_sat;
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            state_q <= slide_start ? ST_READ : ST_IDLE;
            if (is_end) begin
              out_kind_q  <= KIND_FINISHED;
              out_seq_q   <= '0;
              out_data_q  <= '0;
              out_len_q   <= '0;
              out_total_q <= delivered_q;
              out_last_q  <= 1'b1;
            end else if (seq_ok) begin
              out_kind_q  <= KIND_ACK;
              out_seq_q   <= ACK_W'(s_idx);
              out_data_q  <= '0;
              out_len_q   <= '0;
              out_total_q <= delivered_q;
              out_last_q  <= !slide_start;
              if (in_win) begin
                rx_q[s_idx] <= 1'b1;
              end
              if (slide_start) begin
                cnt_q <= '0;
              end
            end
          end
        end
        ST_READ: begin
          state_q <= ST_DELIVER;
        end
        ST_DELIVER: begin
          if (out_free) begin
            out_kind_q   <= KIND_DELIVER;
            out_seq_q    <= ACK_W'(base_q);
            out_data_q   <= DATA_W'(rd_payload);
            out_len_q    <= rd_len;
            out_total_q  <= delivered_nx;
            out_last_q   <= !more;
            delivered_q  <= delivered_nx;
            rx_q[base_q] <= 1'b0;
            base_q       <= base_nx;
            cnt_q        <= cnt_nx[WW-1:0];
            if (!more) begin
              closing_q <= (delivered_nx >= expected_q);
              state_q   <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // configuration writes; a window size write restarts the window
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WINDOW_SIZE: begin
            window_size_q <= cfg_wdata_i[WSIZE_W-1:0];
            rx_q          <= '0;
            base_q        <= '0;
          end
          REG_EXPECTED_BYTES: begin
            expected_q <= cfg_wdata_i[EXP_W-1:0];
          end
          default: begin
            expected_q <= expected_q;
          end
        endcase
      end
    end
  end

  // output ports
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD{1'b0}}, out_total_q, out_len_q, out_data_q, out_seq_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // the window base always lies inside the sequence space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    SPW'(base_q) < space)
    else $error("window base outside sequence space");

  // a delivery only ever reads a slot that is marked received
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIVER) |-> rx_q[base_q])
    else $error("delivery from an empty slot");

  // a slide never delivers more than one window of payloads
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELIVER) |-> (cnt_q < w_eff))
    else $error("slide ran past the window");

  // a finished item is always the final result of its packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KIND_FINISHED)) |-> out_last_q)
    else $error("finished item without last");
`endif

endmodule

`default_nettype wire
